// ===== sv/chunked_body_decoder_core_assert.svh =====
// Assertion helpers shared by the decoder modules.
// Both expect clk_i and rst_ni in the enclosing module.
`ifndef CHUNKED_BODY_DECODER_CORE_ASSERT_SVH
`define CHUNKED_BODY_DECODER_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define CBD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define CBD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== sv/cbd_pkg.sv =====
package cbd_pkg;

  localparam int unsigned SizeWidth = 32;

  // request queue between classifier and parser
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChVt     = 8'h0B;
  localparam logic [7:0] ChFf     = 8'h0C;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChLowerX = 8'h78;
  localparam logic [7:0] ChUpperX = 8'h58;

  localparam logic [1:0] StRunning   = 2'd0;
  localparam logic [1:0] StZeroEnd   = 2'd1;
  localparam logic [1:0] StTruncated = 2'd2;
  localparam logic [1:0] StClean     = 2'd3;

  typedef enum logic [1:0] {
    PH_SIZE,
    PH_DATA,
    PH_SKIP,
    PH_DONE
  } cbd_phase_e;

  // classified input request
  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       fin;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_blank;
    logic       is_x;
    logic       is_cr;
    logic       is_lf;
  } cbd_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       cend;
    logic [1:0] status;
    logic       last;
  } cbd_result_t;

endpackage

// ===== sv/chunked_body_decoder_core.sv =====
// Chunked body decoder: takes one response-body byte per cycle on the slave
// stream while the request queue is not full and returns exactly one result
// per byte on the master stream, in order. Sustained rate is one byte per clock
// while the master stream is not stalled; a classified request is written into
// the 4-entry request queue at the accepting edge, and the parser update moves
// it from there into the output register. The rate is set by the parser's
// state update, which handles one byte per cycle including the size accumulate
// and the remaining-count decrement. Input tuser is first_byte, tlast is
// final_byte. Output tdata is the payload byte (zero on non-payload bytes),
// tuser holds data_valid, chunk_end and status, tlast is end_of_body.
// chunked_mode is written through cfg_we_i/cfg_wdata_i and cleared by reset;
// the user must write it only while the stream is idle, the block does not enforce it.
module chunked_body_decoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,    // chunked_mode
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] body_byte
  input  logic       s_axis_tuser,   // [0] first_byte
  input  logic       s_axis_tlast,   // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [3:0] m_axis_tuser,   // [0] data_valid, [1] chunk_end, [3:2] status
  output logic       m_axis_tlast    // end_of_body
);
  import cbd_pkg::*;

  logic        push;
  logic        full;
  logic        q_valid;
  logic        pop;
  cbd_item_t   in_item;
  cbd_item_t   q_item;
  cbd_result_t res;

  cbd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .push_o        (push),
    .item_o        (in_item),
    .full_i        (full)
  );

  cbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  cbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = {res.status, res.cend, res.valid};
  assign m_axis_tlast = res.last;

endmodule

// ===== sv/cbd_front.sv =====
module cbd_front (
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // body_byte
  input  logic               s_axis_tuser,  // first_byte
  input  logic               s_axis_tlast,  // final_byte
  output logic               push_o,
  output cbd_pkg::cbd_item_t item_o,
  input  logic               full_i
);
  import cbd_pkg::*;

  logic [7:0] b;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !full_i;
  assign push_o        = s_axis_tvalid && !full_i;

  always_comb begin
    item_o          = '0;
    item_o.data     = b;
    item_o.first    = s_axis_tuser;
    item_o.fin      = s_axis_tlast;
    item_o.is_blank = (b == ChSpace) || (b == ChTab) || (b == ChLf) ||
                      (b == ChVt) || (b == ChFf) || (b == ChCr);
    item_o.is_x     = (b == ChLowerX) || (b == ChUpperX);
    item_o.is_cr    = (b == ChCr);
    item_o.is_lf    = (b == ChLf);
    if (b inside {[8'h30:8'h39]}) begin
      item_o.is_hex  = 1'b1;
      item_o.hex_val = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      // 'a'..'f' and 'A'..'F' share the low three bits 1..6
      item_o.is_hex  = 1'b1;
      item_o.hex_val = 4'(b[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

// ===== sv/cbd_queue.sv =====
module cbd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  cbd_pkg::cbd_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output cbd_pkg::cbd_item_t item_o
);
  import cbd_pkg::*;

  cbd_item_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (QPtrW+1)'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QPtrW+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`include "chunked_body_decoder_core_assert.svh"

  `CBD_ASSERT_NEVER(a_q_overflow, count_q > (QPtrW+1)'(QDepth), "queue count past depth")
  `CBD_ASSERT_IMPL(a_q_pop_empty, pop_i, count_q != '0, "pop from empty queue")
  `CBD_ASSERT_IMPL(a_q_push_full, push_i, !full_o, "push into full queue")

endmodule

// ===== sv/cbd_back.sv =====
module cbd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                valid_i,
  input  cbd_pkg::cbd_item_t  item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cbd_pkg::cbd_result_t res_o
);
  import cbd_pkg::*;

  localparam logic [1:0] PpNone = 2'd0;  // nothing but blanks so far
  localparam logic [1:0] PpZero = 2'd1;  // lone leading zero, 'x' may follow
  localparam logic [1:0] PpDone = 2'd2;

  logic                 mode_q;
  cbd_phase_e           phase_q, phase_d;
  logic [SizeWidth-1:0] acc_q, acc_d;
  logic [SizeWidth-1:0] left_q, left_d;
  logic                 hs_q, hs_d;
  logic [1:0]           pp_q, pp_d;
  logic                 pcr_q, pcr_d;
  logic [1:0]           skip_q, skip_d;
  logic                 out_valid_q, out_valid_d;
  cbd_result_t          res_q, res_d;

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    left_d      = left_q;
    hs_d        = hs_q;
    pp_d        = pp_q;
    pcr_d       = pcr_q;
    skip_d      = skip_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (pop_o) begin
      out_valid_d = 1'b1;
      res_d       = '0;
      res_d.last  = item_i.fin;

      if (item_i.first) begin
        phase_d = PH_SIZE;
        acc_d   = '0;
        hs_d    = 1'b0;
        pp_d    = PpNone;
        pcr_d   = 1'b0;
        left_d  = '0;
        skip_d  = '0;
      end

      if (!mode_q) begin
        res_d.valid  = 1'b1;
        res_d.data   = item_i.data;
        res_d.status = item_i.fin ? StClean : StRunning;
      end else begin
        case (phase_d)
          PH_SIZE: begin
            if (pcr_d && item_i.is_lf) begin
              if (acc_d == '0) begin
                phase_d = PH_DONE;
              end else begin
                left_d  = acc_d;
                phase_d = PH_DATA;
              end
            end else begin
              pcr_d = item_i.is_cr;
              if (!hs_d) begin
                if (pp_d == PpZero && item_i.is_x) begin
                  pp_d = PpDone;
                end else if (!(pp_d == PpNone && item_i.is_blank)) begin
                  if (item_i.is_hex) begin
                    // saturate once the top nibble is occupied
                    if (acc_d[SizeWidth-1 -: 4] != '0) begin
                      acc_d = '1;
                    end else begin
                      acc_d = {acc_d[SizeWidth-5:0], item_i.hex_val};
                    end
                    pp_d = (pp_d == PpNone && item_i.hex_val == 4'd0) ? PpZero : PpDone;
                  end else begin
                    hs_d = 1'b1;
                  end
                end
              end
            end
          end
          PH_DATA: begin
            res_d.valid = 1'b1;
            res_d.data  = item_i.data;
            left_d      = left_d - SizeWidth'(1);
            if (left_d == '0) begin
              res_d.cend = 1'b1;
              phase_d    = PH_SKIP;
              skip_d     = 2'd2;
            end
          end
          PH_SKIP: begin
            skip_d = skip_d - 2'd1;
            if (skip_d == 2'd0) begin
              phase_d = PH_SIZE;
              acc_d   = '0;
              hs_d    = 1'b0;
              pp_d    = PpNone;
              pcr_d   = 1'b0;
            end
          end
          PH_DONE: begin
            // trailers are swallowed
          end
          default: begin
            phase_d = PH_SIZE;
          end
        endcase

        if (phase_d == PH_DONE) begin
          res_d.status = StZeroEnd;
        end else if (item_i.fin) begin
          res_d.status = (phase_d == PH_DATA) ? StTruncated : StClean;
        end else begin
          res_d.status = StRunning;
        end
      end

      if (item_i.fin) begin
        phase_d = PH_SIZE;
        acc_d   = '0;
        hs_d    = 1'b0;
        pp_d    = PpNone;
        pcr_d   = 1'b0;
        left_d  = '0;
        skip_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      phase_q     <= PH_SIZE;
      acc_q       <= '0;
      left_q      <= '0;
      hs_q        <= 1'b0;
      pp_q        <= PpNone;
      pcr_q       <= 1'b0;
      skip_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      left_q      <= left_d;
      hs_q        <= hs_d;
      pp_q        <= pp_d;
      pcr_q       <= pcr_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

`include "chunked_body_decoder_core_assert.svh"

  `CBD_ASSERT_IMPL(a_cend_is_data, out_valid_q && res_q.cend, res_q.valid,
                   "chunk end on a non-payload byte")
  `CBD_ASSERT_IMPL(a_end_status_last, out_valid_q && res_q.status[1], res_q.last,
                   "end status without final byte")
  `CBD_ASSERT_IMPL(a_skip_phase, phase_q == PH_SKIP, skip_q != 2'd0,
                   "skip phase with no bytes left to skip")

endmodule

// ===== bench/chunked_body_decoder_core_tb.sv =====
`timescale 1ns / 1ps

module chunked_body_decoder_core_tb;
  import cbd_pkg::*;

  localparam int unsigned MaxCycles   = 400000;
  localparam int unsigned DrainCycles = 20;

  // progress through an optional leading "0x" on a size line
  localparam logic [1:0] PfxNone = 2'd0;
  localparam logic [1:0] PfxZero = 2'd1;
  localparam logic [1:0] PfxDone = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       fin;
  } body_req_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       s_axis_tuser  = 1'b0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic       m_axis_tlast;

  body_req_t   byte_q[$];
  cbd_result_t decoded_q[$];
  logic [7:0]  frame_q[$];

  // decoder state as predicted
  logic                 chunked_on;
  cbd_phase_e           dec_phase;
  logic [SizeWidth-1:0] size_acc;
  logic [SizeWidth-1:0] bytes_left;
  logic                 hex_stopped;
  logic [1:0]           prefix_st;
  logic                 cr_seen;
  logic [1:0]           skip_left;

  int unsigned n_queued, n_sent, n_checked, n_payload, n_cend, n_errors, n_cycles;
  int unsigned n_status[4];
  int unsigned send_gap, tx_calm, stall_left, rx_calm;

  always #2 clk_i = ~clk_i;

  chunked_body_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // ---------------------------------------------------------------- predictor

  function automatic logic [4:0] hex_val(logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return {1'b0, b[3:0]};
    if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h57);
    if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h37);
    return 5'd16;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b == ChSpace || b == ChTab || b == ChLf || b == ChVt || b == ChFf || b == ChCr;
  endfunction

  function automatic void start_line();
    dec_phase   = PH_SIZE;
    size_acc    = '0;
    hex_stopped = 1'b0;
    prefix_st   = PfxNone;
    cr_seen     = 1'b0;
  endfunction

  function automatic void clear_parser();
    start_line();
    bytes_left = '0;
    skip_left  = '0;
  endfunction

  function automatic cbd_result_t decode_byte(body_req_t r);
    cbd_result_t res;
    logic [4:0]  d;
    res = '0;
    if (r.start) clear_parser();
    if (!chunked_on) begin
      res.valid  = 1'b1;
      res.data   = r.data;
      res.status = r.fin ? StClean : StRunning;
    end else begin
      case (dec_phase)
        PH_SIZE: begin
          if (cr_seen && r.data == ChLf) begin
            if (size_acc == '0) begin
              dec_phase = PH_DONE;
            end else begin
              bytes_left = size_acc;
              dec_phase  = PH_DATA;
            end
          end else begin
            cr_seen = (r.data == ChCr);
            if (!hex_stopped) begin
              d = hex_val(r.data);
              if (prefix_st == PfxNone && is_blank(r.data)) begin
                // leading blank
              end else if (prefix_st == PfxZero &&
                           (r.data == ChLowerX || r.data == ChUpperX)) begin
                prefix_st = PfxDone;
              end else if (!d[4]) begin
                if (size_acc > ({SizeWidth{1'b1}} >> 4)) size_acc = '1;
                else size_acc = {size_acc[SizeWidth-5:0], d[3:0]};
                prefix_st = (prefix_st == PfxNone && d == 5'd0) ? PfxZero : PfxDone;
              end else begin
                hex_stopped = 1'b1;
              end
            end
          end
        end
        PH_DATA: begin
          res.valid  = 1'b1;
          res.data   = r.data;
          bytes_left = bytes_left - 1'b1;
          if (bytes_left == '0) begin
            res.cend  = 1'b1;
            dec_phase = PH_SKIP;
            skip_left = 2'd2;
          end
        end
        PH_SKIP: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == 2'd0) start_line();
        end
        default: ;
      endcase
      if (dec_phase == PH_DONE) res.status = StZeroEnd;
      else if (r.fin) res.status = (dec_phase == PH_DATA) ? StTruncated : StClean;
      else res.status = StRunning;
    end
    if (r.fin) clear_parser();
    res.last = r.fin;
    return res;
  endfunction

  // ------------------------------------------------------------------ idling

  // mostly short gaps, a few long, with occasional stretches of none
  function automatic int unsigned gap_len(inout int unsigned calm);
    int unsigned p;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    p = $urandom_range(99);
    if (p < 2) calm = $urandom_range(20, 80);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // -------------------------------------------------------------- driver side

  always @(posedge clk_i) begin : drive_p
    body_req_t r;
    logic      held;
    if (rst_ni) begin
      held = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        decoded_q.insert(decoded_q.size(),
                         decode_byte('{s_axis_tdata, s_axis_tuser, s_axis_tlast}));
        n_sent++;
        held     = 1'b0;
        send_gap = gap_len(tx_calm);
      end
      if (!held) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          r = byte_q.pop_front();
          s_axis_tdata  <= r.data;
          s_axis_tuser  <= r.start;
          s_axis_tlast  <= r.fin;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------- monitor side

  always @(posedge clk_i) begin : check_p
    cbd_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[3:2], m_axis_tlast};
        n_checked++;
        if (got.valid) n_payload++;
        if (got.cend) n_cend++;
        if (got.last) n_status[got.status]++;
        if (decoded_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: result with nothing expected:", $realtime,
                     " data=%h valid=%b cend=%b st=%0d last=%b",
                     got.data, got.valid, got.cend, got.status, got.last);
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("%0t: result %0d mismatch:", $realtime, n_checked,
                       " exp data=%h valid=%b cend=%b st=%0d last=%b",
                       want.data, want.valid, want.cend, want.status, want.last,
                       " | got data=%h valid=%b cend=%b st=%0d last=%b",
                       got.data, got.valid, got.cend, got.status, got.last);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left = gap_len(rx_calm);
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= MaxCycles) begin
      $display("Timeout after %0d cycles, %0d results outstanding", n_cycles, decoded_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------- stimulus

  function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
    if (nib < 4'd10) return 8'h30 + nib;
    return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  task automatic push_byte(logic [7:0] b, logic s, logic f);
    body_req_t r;
    r = '{data: b, start: s, fin: f};
    byte_q.insert(byte_q.size(), r);
    n_queued++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0, 1'b0);
  endtask

  task automatic push_crlf();
    push_byte(ChCr, 1'b0, 1'b0);
    push_byte(ChLf, 1'b0, 1'b0);
  endtask

  function automatic void frame_byte(logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  task automatic add_size_line(int unsigned size, bit huge);
    int unsigned nd;
    logic [3:0]  nib;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(5))
          0: frame_byte(ChSpace);
          1: frame_byte(ChTab);
          2: frame_byte(ChVt);
          3: frame_byte(ChFf);
          4: frame_byte(ChLf);
          default: begin
            // lone CR counts as a blank
            frame_byte(ChCr);
            frame_byte(ChSpace);
          end
        endcase
      end
    end
    if ($urandom_range(3) == 0) begin
      frame_byte(8'h30);
      frame_byte($urandom_range(1) ? ChUpperX : ChLowerX);
    end
    if (huge) begin
      // more digits than the counter holds: saturates
      frame_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(1))));
      repeat ($urandom_range(8, 11))
        frame_byte(hex_char(4'($urandom), 1'($urandom_range(1))));
    end else begin
      if ($urandom_range(5) == 0) frame_byte(8'h30);
      nd = 1;
      while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
      for (int i = nd - 1; i >= 0; i--) begin
        nib = 4'(size >> (4 * i));
        frame_byte(hex_char(nib, 1'($urandom_range(1))));
      end
    end
    case ($urandom_range(9))
      0: begin
        frame_byte(8'h3B);
        repeat ($urandom_range(4)) frame_byte(8'($urandom_range(8'h21, 8'h7E)));
      end
      1: frame_byte($urandom_range(1) ? ChSpace : ChTab);
      2: frame_byte(ChLf);
      3: begin
        frame_byte(ChCr);
        frame_byte(8'h3B);
      end
      default: ;
    endcase
    frame_byte(ChCr);
    frame_byte(ChLf);
  endtask

  // one chunked body, usually well-formed, sometimes cut short
  task automatic gen_body();
    int unsigned sz, keep;
    bit          s;
    frame_q.delete();
    if ($urandom_range(29) == 0) begin
      add_size_line(0, 1'b1);
      repeat ($urandom_range(3, 20)) frame_byte(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(99)) inside
          [0:69]:  sz = $urandom_range(1, 8);
          [70:96]: sz = $urandom_range(9, 40);
          default: sz = $urandom_range(100, 300);
        endcase
        add_size_line(sz, 1'b0);
        repeat (sz) frame_byte(8'($urandom));
        if ($urandom_range(6) != 0) begin
          frame_byte(ChCr);
          frame_byte(ChLf);
        end else begin
          frame_byte(8'($urandom));
          frame_byte(8'($urandom));
        end
      end
      add_size_line(0, 1'b0);
      repeat ($urandom_range(0, 5)) frame_byte(8'($urandom));
      if ($urandom_range(5) == 0) begin
        keep = $urandom_range(1, frame_q.size());
        while (frame_q.size() > keep) frame_q.delete(frame_q.size() - 1);
      end
    end
    s = ($urandom_range(9) != 0);
    foreach (frame_q[i]) push_byte(frame_q[i], s && i == 0, i == frame_q.size() - 1);
  endtask

  task automatic run_chunked(int unsigned budget);
    int unsigned target;
    target = n_queued + budget;
    while (n_queued < target) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6))
          push_byte(8'($urandom), $urandom_range(6) == 0, $urandom_range(6) == 0);
      end else begin
        gen_body();
      end
    end
    // leave a size line open across the next mode change
    push_byte(ChSpace, 1'b1, 1'b0);
    push_byte(hex_char(4'($urandom_range(1, 15)), 1'b0), 1'b0, 1'b0);
  endtask

  task automatic run_passthrough(int unsigned budget);
    repeat (budget)
      push_byte(8'($urandom), $urandom_range(19) == 0, $urandom_range(19) == 0);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (byte_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0);
  endtask

  task automatic write_mode(logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    chunked_on = v;
  endtask

  initial begin
    chunked_on = 1'b0;
    clear_parser();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through extremes
    write_mode(1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    wait_idle();

    // prefix, extension, payload, zero-size end with a trailer byte
    write_mode(1'b1);
    push_byte(ChSpace, 1'b1, 1'b0);
    push_text("0X2;e");
    push_crlf();
    push_text("AB");
    push_crlf();
    push_text("0");
    push_crlf();
    push_byte(8'h54, 1'b0, 1'b1);
    // body cut inside chunk data
    push_byte(8'h33, 1'b1, 1'b0);
    push_crlf();
    push_text("a");
    push_byte(8'h62, 1'b0, 1'b1);
    wait_idle();

    run_chunked(550);
    wait_idle();
    write_mode(1'b0);
    run_passthrough(200);
    wait_idle();
    write_mode(1'b1);
    run_chunked(550);
    wait_idle();
    write_mode(1'b0);
    run_passthrough(120);
    wait_idle();
    write_mode(1'b1);
    run_chunked(250);
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d body bytes, checked %0d results: %0d payload, %0d chunk ends",
             n_sent, n_checked, n_payload, n_cend);
    $display("Bodies closed: %0d zero-size, %0d cut in data, %0d clean, %0d still running",
             n_status[StZeroEnd], n_status[StTruncated], n_status[StClean], n_status[StRunning]);
    if (n_errors == 0 && decoded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", n_errors, decoded_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
